### design/mh3_pkg.sv
// Shared constants and the queued operation type of the MurmurHash3 key hasher.
`timescale 1ns / 1ps
`default_nettype none
package mh3_pkg;

	localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2     = 32'h1b873593;
	localparam logic [31:0] MIX_ADD    = 32'he6546b64;
	localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
	localparam logic [31:0] SEED_RESET = 32'h55aa9966;

	// The table size must be a power of two: the bucket is then a mask of the hash.
	localparam int unsigned TABLE_SIZE = 1024;
	localparam int unsigned BUCKET_W   = 10;
	localparam logic [BUCKET_W-1:0] BUCKET_MASK = BUCKET_W'(TABLE_SIZE - 1);

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One unit of work for the mixing engine: an optional full block to mix,
	// then optionally the tail and finalisation of the key.
	typedef struct packed {
		logic        do_mix;
		logic [31:0] word;
		logic        do_fin;
		logic [23:0] tail;
		logic [1:0]  tail_cnt;
		logic [31:0] key_len;
		logic        first;
		logic [31:0] seed;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

### design/mh3_fifo.sv
// Small flip-flop queue of operations between the byte assembler and the mixing engine.
`timescale 1ns / 1ps
`default_nettype none
module mh3_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mh3_pkg::op_t   wr_op,
	input  wire logic           pop,
	output mh3_pkg::op_t        rd_op,
	output mh3_pkg::q_status_t  status
);
	import mh3_pkg::*;

	op_t                slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign rd_op   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### design/mh3_front.sv
// Byte assembler: takes key bytes, builds little-endian blocks and queues mix and finish work.
`timescale 1ns / 1ps
`default_nettype none
module mh3_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [31:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         key_byte,
	input  wire logic               byte_present,
	input  wire logic               key_end,
	input  wire mh3_pkg::q_status_t q_status,
	output logic                    q_push,
	output mh3_pkg::op_t            q_op
);
	import mh3_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] key_seed_q;
	logic [23:0] part_q;
	logic [1:0]  nbytes_q;
	logic [31:0] len_q;
	logic        first_q;

	logic        accept;
	logic        block_done;
	logic [23:0] part_nx;
	logic [1:0]  nbytes_nx;
	logic [31:0] len_nx;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		part_nx    = part_q;
		nbytes_nx  = nbytes_q;
		len_nx     = len_q;
		block_done = 1'b0;
		if (byte_present) begin
			len_nx = len_q + 32'd1;
			if (nbytes_q == 2'd3) begin
				block_done = 1'b1;
				part_nx    = '0;
				nbytes_nx  = '0;
			end else begin
				case (nbytes_q)
					2'd0:    part_nx[7:0]   = key_byte;
					2'd1:    part_nx[15:8]  = key_byte;
					default: part_nx[23:16] = key_byte;
				endcase
				nbytes_nx = nbytes_q + 2'd1;
			end
		end
	end

	always_comb begin
		q_op.do_mix   = block_done;
		q_op.word     = {key_byte, part_q};
		q_op.do_fin   = key_end;
		q_op.tail     = part_nx;
		q_op.tail_cnt = nbytes_nx;
		q_op.key_len  = len_nx;
		q_op.first    = first_q;
		q_op.seed     = key_seed_q;
	end

	assign q_push = accept && (block_done || key_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= SEED_RESET;
			key_seed_q <= SEED_RESET;
			part_q     <= '0;
			nbytes_q   <= '0;
			len_q      <= '0;
			first_q    <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (accept && key_end) begin
				key_seed_q <= cfg_wr_en ? cfg_wr_data : seed_q;
			end else if (cfg_wr_en && len_q == '0) begin
				// A key with no bytes yet picks up the new seed at once.
				key_seed_q <= cfg_wr_data;
			end
			if (accept) begin
				if (key_end) begin
					part_q     <= '0;
					nbytes_q   <= '0;
					len_q      <= '0;
					first_q    <= 1'b1;
				end else begin
					part_q   <= part_nx;
					nbytes_q <= nbytes_nx;
					len_q    <= len_nx;
					if (block_done) begin
						first_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### design/mh3_back.sv
// Mixing engine: one shared 32-bit multiplier steps through block mixing and finalisation.
`timescale 1ns / 1ps
`default_nettype none
module mh3_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mh3_pkg::op_t        q_op,
	input  wire mh3_pkg::q_status_t  q_status,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [31:0]              full_hash,
	output logic [mh3_pkg::BUCKET_W-1:0] bucket
);
	import mh3_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MIX  = 3'd3;
	localparam logic [2:0] ST_FIN1 = 3'd4;
	localparam logic [2:0] ST_FIN2 = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]  state_q;
	logic        do_fin_q;
	logic [23:0] tail_q;
	logic [1:0]  tail_cnt_q;
	logic [31:0] len_q;
	logic [31:0] h_q;
	logic [31:0] acc_q;
	logic        tail_phase_q;
	logic [31:0] hash_q;
	logic        out_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;
	logic [31:0] fin_x;
	logic [31:0] mix_x;
	logic [31:0] mix_r;
	logic        out_free;

	assign fin_x = (h_q ^ len_q) ^ ((h_q ^ len_q) >> 16);
	assign mix_x = h_q ^ acc_q;
	assign mix_r = {mix_x[18:0], mix_x[31:19]};

	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = acc_q;
				mul_b = MIX_C1;
			end
			ST_MUL2: begin
				mul_a = {acc_q[16:0], acc_q[31:17]};
				mul_b = MIX_C2;
			end
			ST_FIN1: begin
				mul_a = fin_x;
				mul_b = FIN_M1;
			end
			default: begin
				mul_a = acc_q ^ (acc_q >> 13);
				mul_b = FIN_M2;
			end
		endcase
	end

	assign mul_p = 32'(mul_a * mul_b);

	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_status.empty;
	assign out_valid = out_valid_q;
	assign full_hash = hash_q;
	assign bucket    = hash_q[BUCKET_W-1:0] & BUCKET_MASK;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					do_fin_q   <= q_op.do_fin;
					tail_q     <= q_op.tail;
					tail_cnt_q <= q_op.tail_cnt;
					len_q      <= q_op.key_len;
					if (q_op.first) begin
						h_q <= q_op.seed;
					end
					if (q_op.do_mix) begin
						acc_q        <= q_op.word;
						tail_phase_q <= 1'b0;
					end else begin
						acc_q        <= {8'd0, q_op.tail};
						tail_phase_q <= 1'b1;
					end
				end
			end
			ST_MUL1, ST_MUL2, ST_FIN1, ST_FIN2: begin
				acc_q <= mul_p;
			end
			ST_MIX: begin
				if (tail_phase_q) begin
					h_q <= mix_x;
				end else begin
					h_q          <= {mix_r[29:0], 2'b00} + mix_r + MIX_ADD;
					acc_q        <= {8'd0, tail_q};
					tail_phase_q <= 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					hash_q <= acc_q ^ (acc_q >> 16);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						if (q_op.do_mix || q_op.tail_cnt != 2'd0) begin
							state_q <= ST_MUL1;
						end else if (q_op.do_fin) begin
							state_q <= ST_FIN1;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MIX;
				ST_MIX: begin
					if (tail_phase_q) begin
						state_q <= ST_FIN1;
					end else if (!do_fin_q) begin
						state_q <= ST_IDLE;
					end else if (tail_cnt_q != 2'd0) begin
						state_q <= ST_MUL1;
					end else begin
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/murmur3_string_bucket_hash_top.sv
// Top level of the MurmurHash3 (x86, 32-bit) string hasher with bucket output.
`timescale 1ns / 1ps
`default_nettype none
// Keys arrive one byte per item with a flag for the last byte; each key gives
// one result holding its 32-bit MurmurHash3 and the bucket (the hash modulo
// the table size). The byte assembler takes one item per cycle while the
// four-entry operation queue has room. The mixing engine shares one 32-bit
// multiplier: a full 4-byte block steps through MUL1, MUL2 and MIX; finishing
// a key steps through FIN1, FIN2 and OUT, with no return to IDLE after a block
// that the last byte completed, and a 1 to 3 byte tail adds MUL1, MUL2 and MIX.
// A result that has not been taken holds the engine in its last step until the
// output register is free. The sustained rate is about one byte per cycle on
// long keys, limited by the multiplier sequence of the engine. A seed write
// applies from the next key, or at once if the current key has no bytes yet.
module murmur3_string_bucket_hash_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  key_byte,
	input  wire logic        byte_present,
	input  wire logic        key_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      full_hash,
	output logic [mh3_pkg::BUCKET_W-1:0] bucket
);
	import mh3_pkg::*;

	op_t       wr_op;
	op_t       rd_op;
	q_status_t q_status;
	logic      q_push;
	logic      q_pop;

	mh3_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_byte     (key_byte),
		.byte_present (byte_present),
		.key_end      (key_end),
		.q_status     (q_status),
		.q_push       (q_push),
		.q_op         (wr_op)
	);

	mh3_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_op  (wr_op),
		.pop    (q_pop),
		.rd_op  (rd_op),
		.status (q_status)
	);

	mh3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_op      (rd_op),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.full_hash (full_hash),
		.bucket    (bucket)
	);

endmodule
`default_nettype wire

### verif/tb_murmur3_string_bucket_hash_top.sv
// Self-checking testbench for the MurmurHash3 string hasher with bucket output.
`timescale 1ns / 1ps
module tb_murmur3_string_bucket_hash_top;
	import mh3_pkg::*;

	// Settle time after the last result, enough for the operation queue to empty.
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned RANDOM_ITEMS  = 1700;

	typedef struct packed {
		logic [31:0]         hash;
		logic [BUCKET_W-1:0] bucket;
	} key_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [31:0]         cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          key_byte = '0;
	logic                byte_present = 1'b0;
	logic                key_end = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [31:0]         full_hash;
	logic [BUCKET_W-1:0] bucket;

	// Hasher state as seen from outside, advanced on every accepted item.
	logic [31:0] cur_seed = SEED_RESET;
	logic [31:0] acc_hash = SEED_RESET;
	logic [23:0] tail_bytes = '0;
	logic [1:0]  tail_count = '0;
	logic [31:0] byte_count = '0;

	key_result_t pending_hashes[$];
	key_result_t want_result;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned random_items = 0;
	int unsigned idle_run = 0;

	logic        hold_trigger = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;
	logic [11:0] rx_cycle = '0;

	murmur3_string_bucket_hash_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_byte     (key_byte),
		.byte_present (byte_present),
		.key_end      (key_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.full_hash    (full_hash),
		.bucket       (bucket)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] scramble_block(input logic [31:0] k);
		logic [31:0] t;
		t = k * MIX_C1;
		t = rotate_left(t, 15);
		return t * MIX_C2;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40) begin
			$display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
		end
		mismatches++;
	endtask

	task automatic restart_key();
		acc_hash = cur_seed;
		tail_bytes = '0;
		tail_count = '0;
		byte_count = '0;
	endtask

	// Folds one accepted item into the key state and queues the hash it finishes.
	task automatic fold_key_item(input logic [7:0] b, input logic present, input logic last);
		logic [31:0] h;
		key_result_t r;
		if (present) begin
			byte_count = byte_count + 32'd1;
			if (tail_count == 2'd3) begin
				acc_hash = acc_hash ^ scramble_block({b, tail_bytes});
				acc_hash = rotate_left(acc_hash, 13) * 32'd5 + MIX_ADD;
				tail_bytes = '0;
				tail_count = '0;
			end else begin
				tail_bytes = tail_bytes | (24'(b) << (8 * tail_count));
				tail_count = tail_count + 2'd1;
			end
		end
		if (last) begin
			h = acc_hash;
			if (tail_count != 2'd0)
				h = h ^ scramble_block({8'h00, tail_bytes});
			h = h ^ byte_count;
			h = h ^ (h >> 16);
			h = h * FIN_M1;
			h = h ^ (h >> 13);
			h = h * FIN_M2;
			h = h ^ (h >> 16);
			r.hash = h;
			r.bucket = BUCKET_W'(h % TABLE_SIZE);
			pending_hashes.push_back(r);
			restart_key();
		end
	endtask

	// Called at a rising edge; returns after the item is taken and any idle gap.
	task automatic send_key_item(input logic [7:0] b, input logic present, input logic last);
		in_valid <= 1'b1;
		key_byte <= b;
		byte_present <= present;
		key_end <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fold_key_item(b, present, last);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_until_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_seed(input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cur_seed = value;
		if (byte_count == 32'd0 && tail_count == 2'd0)
			acc_hash = value;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] rand_key_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_key();
		int unsigned len;
		int unsigned pick;
		logic joined_end;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			len = 0;
		else if (pick < 85)
			len = $urandom_range(1, 12);
		else
			len = $urandom_range(13, 48);
		joined_end = (len != 0) && ($urandom_range(0, 1) == 1);
		for (int unsigned i = 0; i < len; i++) begin
			// Occasional empty items, which the block must ignore.
			if ($urandom_range(0, 19) == 0)
				send_key_item(rand_key_byte(), 1'b0, 1'b0);
			send_key_item(rand_key_byte(), 1'b1, joined_end && (i == len - 1));
			random_items++;
		end
		if (!joined_end) begin
			send_key_item(rand_key_byte(), 1'b0, 1'b1);
			random_items++;
		end
	endtask

	task automatic test_key_edges();
		// Empty key, with a byte on the bus that is not part of it.
		send_key_item(8'hff, 1'b0, 1'b1);
		send_key_item(8'h61, 1'b1, 1'b1);
		// Zero bytes are ordinary bytes; an empty item in the middle changes nothing.
		send_key_item(8'h00, 1'b1, 1'b0);
		send_key_item(8'h00, 1'b1, 1'b0);
		send_key_item(8'h00, 1'b0, 1'b0);
		send_key_item(8'h00, 1'b1, 1'b1);
		send_key_item(8'hff, 1'b1, 1'b0);
		send_key_item(8'h00, 1'b1, 1'b0);
		send_key_item(8'hff, 1'b1, 1'b0);
		send_key_item(8'h80, 1'b1, 1'b1);
		send_key_item(8'h12, 1'b1, 1'b0);
		send_key_item(8'h34, 1'b1, 1'b0);
		send_key_item(8'h56, 1'b1, 1'b0);
		send_key_item(8'h78, 1'b1, 1'b0);
		send_key_item(8'h9a, 1'b1, 1'b0);
		send_key_item(8'hbc, 1'b0, 1'b1);
		wait_until_idle();
	endtask

	task automatic test_seed_updates();
		// After a key ends the new seed applies at once.
		write_seed(32'h0000_0000);
		send_key_item(8'h5a, 1'b1, 1'b1);
		wait_until_idle();
		write_seed(32'hffff_ffff);
		send_key_item(8'ha5, 1'b1, 1'b0);
		send_key_item(8'h3c, 1'b1, 1'b1);
		// A write in the middle of a key only applies from the next key.
		send_key_item(8'h01, 1'b1, 1'b0);
		send_key_item(8'hfe, 1'b1, 1'b0);
		wait_until_idle();
		write_seed(32'h1357_9bdf);
		send_key_item(8'h00, 1'b0, 1'b1);
		send_key_item(8'h77, 1'b1, 1'b1);
		wait_until_idle();
	endtask

	task automatic test_input_backpressure();
		// The receiver holds off while short keys keep coming, so the queue fills.
		hold_trigger <= ~hold_trigger;
		for (int i = 0; i < 24; i++) begin
			send_key_item(rand_key_byte(), 1'b1, 1'b0);
			send_key_item(rand_key_byte(), 1'b1, 1'b1);
		end
		wait_until_idle();
	endtask

	task automatic test_random_keys();
		logic [31:0] phase_seed[4];
		phase_seed[0] = $urandom();
		phase_seed[1] = 32'h0000_0000;
		phase_seed[2] = 32'hffff_ffff;
		phase_seed[3] = SEED_RESET;
		random_items = 0;
		for (int p = 0; p < 4; p++) begin
			write_seed(phase_seed[p]);
			while (random_items < (p + 1) * (RANDOM_ITEMS / 4))
				send_random_key();
			wait_until_idle();
		end
		write_seed($urandom());
		repeat (6) send_random_key();
		wait_until_idle();
	endtask

	// Result side: checks each taken result and drives a changing stall pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_hashes.size() == 0) begin
					report_mismatch("unexpected result", full_hash, 32'h0);
				end else begin
					want_result = pending_hashes.pop_front();
					if (full_hash !== want_result.hash)
						report_mismatch("full_hash", full_hash, want_result.hash);
					if (bucket !== want_result.bucket)
						report_mismatch("bucket", 32'(bucket), 32'(want_result.bucket));
				end
			end
			rx_cycle <= rx_cycle + 12'd1;
			if (hold_trigger != hold_seen) begin
				hold_seen <= hold_trigger;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				case (rx_cycle[10:9])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= ($urandom_range(0, 1) == 1);
					2'd2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= (rx_cycle[2:0] != 3'd5);
				endcase
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	initial begin
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_edges();
		test_seed_updates();
		test_input_backpressure();
		test_random_keys();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
